### rtl/slsc_pkg.sv
`default_nettype none

package slsc_pkg;

  localparam int unsigned ANGLE_MAX   = 180;
  localparam logic [7:0]  ANGLE_MAX_B = 8'(ANGLE_MAX);
  localparam logic [7:0]  ANGLE_SAT   = 8'd255;

  // angle * span fits in PROD_W bits for any ANGLE_MAX up to 255
  localparam int unsigned PROD_W      = 24;
  localparam int unsigned RECIP_W     = PROD_W + 1;
  localparam int unsigned MUL_W       = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_ANGLE =
    RECIP_W'((64'd1 << PROD_W) / ANGLE_MAX);

  localparam logic [15:0] RST_SERVO_MIN_PULSE = 16'd500;
  localparam logic [15:0] RST_SERVO_SPAN      = 16'd1000;
  localparam logic [15:0] RST_SERVO_FRAME     = 16'd20000;
  localparam logic [7:0]  RST_SERVO_REPEATS   = 8'd20;
  localparam logic [15:0] RST_TONE_HALF       = 16'd500;
  localparam logic [15:0] RST_TONE_CYCLES     = 16'd500;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_S     = 8'h53;

  typedef enum logic [2:0] {
    CFG_SERVO_MIN_PULSE = 3'd0,
    CFG_SERVO_SPAN      = 3'd1,
    CFG_SERVO_FRAME     = 3'd2,
    CFG_SERVO_REPEATS   = 3'd3,
    CFG_TONE_HALF       = 3'd4,
    CFG_TONE_CYCLES     = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_SERVO = 3'b010,
    MODE_TONE  = 3'b100
  } mode_t;

  typedef enum logic [3:0] {
    PH_BLANKS = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_OK   = 2'd1,
    REPLY_BAD  = 2'd2
  } reply_t;

  typedef struct packed {
    logic servo;
    logic tone;
    logic led;
    logic bad;
  } cmd_t;

  typedef struct packed {
    logic servo;
    logic buzzer;
    logic led0;
    logic led1;
  } pins_t;

  typedef struct packed {
    logic [15:0] frame;
    logic [7:0]  repeats;
    logic [15:0] half;
    logic [15:0] cycles;
  } tmr_cfg_t;

  typedef struct packed {
    logic active;
    logic done;
    logic servo_pin;
    logic buzzer_pin;
  } tmr_status_t;

endpackage

`default_nettype wire

### rtl/slsc_parse.sv
`default_nettype none

module slsc_parse (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         byte_en,
  input  wire logic [7:0]   rx_byte,
  output slsc_pkg::cmd_t    cmd,
  output logic [7:0]        angle,
  output logic [1:0]        led_nxt
);
  import slsc_pkg::*;

  logic [7:0]  first_r, first_nxt;
  logic [7:0]  second_r, second_nxt;
  logic [1:0]  chars_r, chars_nxt;
  phase_t      phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic [7:0]  angle_r, angle_nxt;
  logic [1:0]  led_r;
  logic        is_digit, is_blank, is_sign, line_end;
  logic [11:0] acc;
  logic [7:0]  acc_sat, f, s;

  assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
  assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) || (rx_byte == CH_VT) ||
                    (rx_byte == CH_FF) || (rx_byte == CH_CR);
  assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
  assign line_end = byte_en && (rx_byte == CH_NL);

  assign acc     = 12'(angle_r) * 12'd10 + 12'(rx_byte - CH_0);
  assign acc_sat = (acc > 12'(ANGLE_SAT)) ? ANGLE_SAT : acc[7:0];

  assign f = (chars_r != 2'd0) ? first_r : 8'd0;
  assign s = (chars_r >= 2'd2) ? second_r : 8'd0;

  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    chars_nxt  = chars_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    angle_nxt  = angle_r;
    if (line_end) begin
      chars_nxt = 2'd0;
      phase_nxt = PH_BLANKS;
      neg_nxt   = 1'b0;
      angle_nxt = 8'd0;
    end else if (byte_en) begin
      if (chars_r == 2'd0) begin
        first_nxt = rx_byte;
      end else if (chars_r == 2'd1) begin
        second_nxt = rx_byte;
      end
      if (chars_r != 2'd0) begin
        unique case (phase_r)
          PH_BLANKS: begin
            if (is_blank) begin
              phase_nxt = PH_BLANKS;
            end else if (is_sign) begin
              neg_nxt   = (rx_byte == CH_MINUS);
              phase_nxt = PH_SIGN;
            end else if (is_digit) begin
              phase_nxt = PH_DIGITS;
              angle_nxt = acc_sat;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            if (is_digit) begin
              phase_nxt = PH_DIGITS;
              angle_nxt = acc_sat;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: phase_nxt = PH_DONE;
          default: phase_nxt = phase_r;
        endcase
      end
      if (chars_r != 2'd3) begin
        chars_nxt = chars_r + 2'd1;
      end
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.servo = line_end && (f == CH_S);
    cmd.tone  = line_end && (f == CH_B);
    cmd.led   = line_end && (f == CH_L);
    cmd.bad   = line_end && (f != CH_S) && (f != CH_B) && (f != CH_L);
    led_nxt   = led_r;
    if (cmd.led) begin
      if (s == CH_1) begin
        led_nxt = led_r | 2'b01;
      end else if (s == CH_2) begin
        led_nxt = led_r | 2'b10;
      end else if (s == CH_0) begin
        led_nxt = 2'b00;
      end
    end
  end

  assign angle = neg_r ? 8'd0 : ((angle_r > ANGLE_MAX_B) ? ANGLE_MAX_B : angle_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 8'd0;
      second_r <= 8'd0;
      chars_r  <= 2'd0;
      phase_r  <= PH_BLANKS;
      neg_r    <= 1'b0;
      angle_r  <= 8'd0;
      led_r    <= 2'b00;
    end else begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      chars_r  <= chars_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      angle_r  <= angle_nxt;
      led_r    <= led_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/slsc_scale.sv
`default_nettype none

module slsc_scale (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        touch,
  input  wire logic [7:0]  angle,
  input  wire logic [15:0] span,
  input  wire logic [15:0] min_pulse,
  output logic [15:0]      pw,
  output logic             fresh
);
  import slsc_pkg::*;

  logic [PROD_W-1:0] prod_r, prod_d_r, rem;
  logic [MUL_W-1:0]  mul;
  logic [15:0]       qest_r, quot_r, quot_nxt;
  logic [16:0]       sum;
  logic [1:0]        stale_r, stale_nxt;

  assign mul = MUL_W'(prod_r) * MUL_W'(RECIP_ANGLE);
  assign rem = prod_d_r - PROD_W'(qest_r) * PROD_W'(ANGLE_MAX);
  assign quot_nxt = (rem >= PROD_W'(ANGLE_MAX)) ? qest_r + 16'd1 : qest_r;

  always_ff @(posedge clk) begin
    prod_r   <= PROD_W'(angle) * PROD_W'(span);
    prod_d_r <= prod_r;
    qest_r   <= mul[PROD_W+15:PROD_W];
    quot_r   <= quot_nxt;
  end

  assign sum = 17'(min_pulse) + 17'(quot_r);
  assign pw  = sum[16] ? 16'hFFFF : sum[15:0];

  // hold off a newline until a changed angle or span has passed all three stages
  always_comb begin
    stale_nxt = stale_r;
    if (touch) begin
      stale_nxt = 2'd3;
    end else if (stale_r != 2'd0) begin
      stale_nxt = stale_r - 2'd1;
    end
  end

  assign fresh = (stale_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= 2'd3;
    end else begin
      stale_r <= stale_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/slsc_timer.sv
`default_nettype none

module slsc_timer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              tick_en,
  input  wire logic              start_servo,
  input  wire logic              start_tone,
  input  wire logic [15:0]       pw_in,
  input  wire slsc_pkg::tmr_cfg_t cfg,
  output slsc_pkg::tmr_status_t  st
);
  import slsc_pkg::*;

  mode_t       mode_r, mode_nxt, enter_mode;
  logic [15:0] rep_r, rep_nxt, enter_rep, rep_dec, start_cnt;
  logic [15:0] count_r, count_nxt;
  logic        high_r, high_nxt;
  logic [15:0] pw_r, pw_nxt, sel_pw, hlen, llen, plen;
  logic        sel_servo, enter, done;
  logic [16:0] inc;

  assign sel_pw    = start_servo ? pw_in : pw_r;
  assign sel_servo = start_servo || (!start_tone && (mode_r == MODE_SERVO));
  assign hlen      = sel_servo ? sel_pw : cfg.half;
  assign llen      = sel_servo ? ((cfg.frame > sel_pw) ? cfg.frame - sel_pw : 16'd0)
                               : cfg.half;
  assign plen      = high_r ? hlen : llen;
  assign inc       = 17'(count_r) + 17'd1;
  assign rep_dec   = rep_r - 16'd1;
  assign start_cnt = start_servo ? 16'(cfg.repeats) : cfg.cycles;

  always_comb begin
    mode_nxt   = mode_r;
    rep_nxt    = rep_r;
    count_nxt  = count_r;
    high_nxt   = high_r;
    pw_nxt     = start_servo ? pw_in : pw_r;
    done       = 1'b0;
    enter      = 1'b0;
    enter_rep  = rep_r;
    enter_mode = mode_r;
    if (start_servo || start_tone) begin
      count_nxt = 16'd0;
      if (start_cnt == 16'd0) begin
        mode_nxt = MODE_IDLE;
        high_nxt = 1'b0;
        done     = 1'b1;
      end else begin
        enter      = 1'b1;
        enter_rep  = start_cnt;
        enter_mode = start_servo ? MODE_SERVO : MODE_TONE;
      end
    end else if (tick_en && (mode_r != MODE_IDLE)) begin
      if (inc < 17'(plen)) begin
        count_nxt = inc[15:0];
      end else begin
        count_nxt = 16'd0;
        high_nxt  = 1'b0;
        // low phase over, or high phase over into an empty low phase
        if (!high_r || (llen == 16'd0)) begin
          if (rep_dec == 16'd0) begin
            rep_nxt  = rep_dec;
            mode_nxt = MODE_IDLE;
            done     = 1'b1;
          end else begin
            enter     = 1'b1;
            enter_rep = rep_dec;
          end
        end
      end
    end
    if (enter) begin
      rep_nxt   = enter_rep;
      mode_nxt  = enter_mode;
      count_nxt = 16'd0;
      if (hlen != 16'd0) begin
        high_nxt = 1'b1;
      end else if (llen != 16'd0) begin
        high_nxt = 1'b0;
      end else begin
        // both phases empty: every remaining frame ends at once
        high_nxt = 1'b0;
        mode_nxt = MODE_IDLE;
        done     = 1'b1;
      end
    end
  end

  always_comb begin
    st            = '0;
    st.active     = (mode_r != MODE_IDLE);
    st.done       = done;
    st.servo_pin  = (mode_nxt == MODE_SERVO) && high_nxt;
    st.buzzer_pin = (mode_nxt == MODE_TONE) && high_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      rep_r   <= 16'd0;
      count_r <= 16'd0;
      high_r  <= 1'b0;
      pw_r    <= 16'd0;
    end else begin
      mode_r  <= mode_nxt;
      rep_r   <= rep_nxt;
      count_r <= count_nxt;
      high_r  <= high_nxt;
      pw_r    <= pw_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/slsc_out.sv
`default_nettype none

module slsc_out (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire slsc_pkg::pins_t  pins_in,
  input  wire slsc_pkg::reply_t reply_in,
  output logic                 can_load,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_servo_pin,
  output logic                 out_buzzer_pin,
  output logic                 out_led_zero,
  output logic                 out_led_one,
  output logic                 out_reply_valid,
  output logic [7:0]           out_reply_byte,
  output logic                 out_last
);
  import slsc_pkg::*;

  logic       vld_r;
  logic [1:0] beat_r;
  pins_t      pins_r;
  reply_t     reply_r;
  logic       take;

  always_comb begin
    out_last       = 1'b1;
    out_reply_byte = 8'd0;
    case (reply_r)
      REPLY_OK: begin
        out_last = (beat_r == 2'd2);
        case (beat_r)
          2'd0:    out_reply_byte = CH_O;
          2'd1:    out_reply_byte = CH_K;
          default: out_reply_byte = CH_NL;
        endcase
      end
      REPLY_BAD: begin
        out_last       = (beat_r == 2'd1);
        out_reply_byte = (beat_r == 2'd0) ? CH_QUERY : CH_NL;
      end
      default: begin
        out_last       = 1'b1;
        out_reply_byte = 8'd0;
      end
    endcase
  end

  assign out_valid       = vld_r;
  assign out_reply_valid = (reply_r != REPLY_NONE);
  assign out_servo_pin   = pins_r.servo;
  assign out_buzzer_pin  = pins_r.buzzer;
  assign out_led_zero    = pins_r.led0;
  assign out_led_one     = pins_r.led1;

  assign take     = vld_r && out_ready;
  assign can_load = !vld_r || (take && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      beat_r <= 2'd0;
    end else if (load) begin
      vld_r  <= 1'b1;
      beat_r <= 2'd0;
    end else if (take) begin
      if (out_last) begin
        vld_r <= 1'b0;
      end else begin
        beat_r <= beat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pins_r  <= pins_in;
      reply_r <= reply_in;
    end
  end

endmodule

`default_nettype wire

### rtl/serial_line_servo_tone_led_controller_core.sv
// An accepted item shows its first result on the next cycle, from a register.
// One item per cycle while each gives a single result and out_ready is high; a
// reply holds the input until its two or three results are taken, and a newline
// right after a byte or a register write waits for the pulse width
// multiply-divide pipeline.
// Reset (synchronous, rst_n low): parser, timer, LEDs, output and registers to defaults.
`default_nettype none

module serial_line_servo_tone_led_controller_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_servo_pin,
  output logic             out_buzzer_pin,
  output logic             out_led_zero,
  output logic             out_led_one,
  output logic             out_reply_valid,
  output logic [7:0]       out_reply_byte,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import slsc_pkg::*;

  logic [15:0] min_pulse_r, span_r, frame_r, half_r, cycles_r;
  logic [7:0]  repeats_r;
  logic        cfg_we, in_acc, byte_en, tick_en, can_load, fresh;
  logic [7:0]  angle;
  logic [15:0] pw;
  logic [1:0]  led_nxt;
  cmd_t        cmd;
  tmr_cfg_t    tcfg;
  tmr_status_t tst;
  pins_t       pins;
  reply_t      reply;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r <= RST_SERVO_MIN_PULSE;
      span_r      <= RST_SERVO_SPAN;
      frame_r     <= RST_SERVO_FRAME;
      repeats_r   <= RST_SERVO_REPEATS;
      half_r      <= RST_TONE_HALF;
      cycles_r    <= RST_TONE_CYCLES;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SERVO_MIN_PULSE: min_pulse_r <= cfg_data;
        CFG_SERVO_SPAN:      span_r      <= cfg_data;
        CFG_SERVO_FRAME:     frame_r     <= cfg_data;
        CFG_SERVO_REPEATS:   repeats_r   <= cfg_data[7:0];
        CFG_TONE_HALF:       half_r      <= cfg_data;
        CFG_TONE_CYCLES:     cycles_r    <= cfg_data;
        default:             ;
      endcase
    end
  end

  assign in_ready = can_load && (in_opcode || (in_rx_byte != CH_NL) || fresh);
  assign in_acc   = in_valid && in_ready;
  assign byte_en  = in_acc && !in_opcode && !tst.active;
  assign tick_en  = in_acc && in_opcode;

  assign tcfg.frame   = frame_r;
  assign tcfg.repeats = repeats_r;
  assign tcfg.half    = half_r;
  assign tcfg.cycles  = cycles_r;

  slsc_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .rx_byte (in_rx_byte),
    .cmd     (cmd),
    .angle   (angle),
    .led_nxt (led_nxt)
  );

  slsc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .touch     (byte_en || cfg_we),
    .angle     (angle),
    .span      (span_r),
    .min_pulse (min_pulse_r),
    .pw        (pw),
    .fresh     (fresh)
  );

  slsc_timer u_timer (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (tick_en),
    .start_servo (cmd.servo),
    .start_tone  (cmd.tone),
    .pw_in       (pw),
    .cfg         (tcfg),
    .st          (tst)
  );

  always_comb begin
    pins.servo  = tst.servo_pin;
    pins.buzzer = tst.buzzer_pin;
    pins.led0   = led_nxt[0];
    pins.led1   = led_nxt[1];
    if (tst.done || cmd.led) begin
      reply = REPLY_OK;
    end else if (cmd.bad) begin
      reply = REPLY_BAD;
    end else begin
      reply = REPLY_NONE;
    end
  end

  slsc_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (in_acc),
    .pins_in         (pins),
    .reply_in        (reply),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_servo_pin   (out_servo_pin),
    .out_buzzer_pin  (out_buzzer_pin),
    .out_led_zero    (out_led_zero),
    .out_led_one     (out_led_one),
    .out_reply_valid (out_reply_valid),
    .out_reply_byte  (out_reply_byte),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

### sim/tb_serial_line_servo_tone_led_controller_core.sv
`default_nettype none

module tb_serial_line_servo_tone_led_controller_core;
  import slsc_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic       servo;
    logic       buzzer;
    logic       led0;
    logic       led1;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       last_item;
  } pin_reply_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = OP_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_servo_pin;
  logic        out_buzzer_pin;
  logic        out_led_zero;
  logic        out_led_one;
  logic        out_reply_valid;
  logic [7:0]  out_reply_byte;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'h0000;

  serial_line_servo_tone_led_controller_core dut (.*);

  // register copies
  logic [15:0] reg_min_pulse = RST_SERVO_MIN_PULSE;
  logic [15:0] reg_span      = RST_SERVO_SPAN;
  logic [15:0] reg_frame     = RST_SERVO_FRAME;
  logic [7:0]  reg_repeats   = RST_SERVO_REPEATS;
  logic [15:0] reg_half      = RST_TONE_HALF;
  logic [15:0] reg_cycles    = RST_TONE_CYCLES;

  // parser and timer state
  logic [7:0]  first_ch = 8'h00;
  logic [7:0]  second_ch = 8'h00;
  int unsigned chars_n = 0;
  phase_t      num_phase = PH_BLANKS;
  logic        num_negative = 1'b0;
  int unsigned magnitude = 0;
  mode_t       act_mode = MODE_IDLE;
  logic [15:0] reps_left = 16'd0;
  int unsigned us_count = 0;
  logic        high_ph = 1'b0;
  logic [15:0] pulse_w = 16'd0;
  logic [1:0]  leds = 2'b00;

  pin_reply_t  expected_q[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 16);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VT;
      3: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic int unsigned phase_len();
    if (act_mode == MODE_SERVO) begin
      if (high_ph) return pulse_w;
      return (reg_frame > pulse_w) ? reg_frame - pulse_w : 0;
    end
    return reg_half;
  endfunction

  // close out every phase that has already run its length
  function automatic bit settle();
    while (act_mode != MODE_IDLE && us_count >= phase_len()) begin
      us_count = 0;
      if (high_ph) begin
        high_ph = 1'b0;
      end else begin
        reps_left = reps_left - 16'd1;
        if (reps_left == 16'd0) begin
          act_mode = MODE_IDLE;
          return 1'b1;
        end
        high_ph = 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit start_action(mode_t m, int unsigned count);
    us_count = 0;
    if (count == 0) begin
      act_mode = MODE_IDLE;
      high_ph = 1'b0;
      return 1'b1;
    end
    act_mode = m;
    reps_left = 16'(count);
    high_ph = 1'b1;
    return settle();
  endfunction

  function automatic void feed_number(logic [7:0] c);
    bit digit;
    bit blank;
    digit = (c >= CH_0) && (c <= CH_9);
    blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
            (c == CH_CR);
    if (num_phase == PH_BLANKS) begin
      if (blank) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        num_negative = (c == CH_MINUS);
        num_phase = PH_SIGN;
        return;
      end
    end
    if (num_phase == PH_DONE) return;
    if (!digit) begin
      num_phase = PH_DONE;
      return;
    end
    num_phase = PH_DIGITS;
    magnitude = magnitude * 10 + (c - CH_0);
    if (magnitude > 255) magnitude = 255;
  endfunction

  function automatic void push_result(logic rv, logic [7:0] rb, logic last_f);
    pin_reply_t r;
    r.servo = (act_mode == MODE_SERVO) && high_ph;
    r.buzzer = (act_mode == MODE_TONE) && high_ph;
    r.led0 = leds[0];
    r.led1 = leds[1];
    r.reply_valid = rv;
    r.reply_byte = rb;
    r.last_item = last_f;
    expected_q.push_back(r);
  endfunction

  function automatic void push_ok();
    push_result(1'b1, CH_O, 1'b0);
    push_result(1'b1, CH_K, 1'b0);
    push_result(1'b1, CH_NL, 1'b1);
  endfunction

  function automatic void predict_item(logic op, logic [7:0] b);
    bit done;
    logic [7:0] f;
    logic [7:0] s;
    int unsigned ang;
    int unsigned w;
    done = 1'b0;
    if (op == OP_TICK) begin
      if (act_mode != MODE_IDLE) begin
        us_count++;
        done = settle();
      end
      if (done) push_ok();
      else push_result(1'b0, 8'h00, 1'b1);
      return;
    end
    // drop bytes while an action runs
    if (act_mode != MODE_IDLE) begin
      push_result(1'b0, 8'h00, 1'b1);
      return;
    end
    if (b != CH_NL) begin
      if (chars_n == 0) first_ch = b;
      else if (chars_n == 1) second_ch = b;
      if (chars_n >= 1) feed_number(b);
      if (chars_n < 3) chars_n++;
      push_result(1'b0, 8'h00, 1'b1);
      return;
    end
    f = (chars_n >= 1) ? first_ch : 8'h00;
    s = (chars_n >= 2) ? second_ch : 8'h00;
    ang = num_negative ? 0 : ((magnitude > ANGLE_MAX) ? ANGLE_MAX : magnitude);
    chars_n = 0;
    num_phase = PH_BLANKS;
    num_negative = 1'b0;
    magnitude = 0;
    if (f == CH_S) begin
      w = reg_min_pulse + (ang * reg_span) / ANGLE_MAX;
      pulse_w = (w > 32'hFFFF) ? 16'hFFFF : 16'(w);
      done = start_action(MODE_SERVO, reg_repeats);
    end else if (f == CH_B) begin
      done = start_action(MODE_TONE, reg_cycles);
    end else if (f == CH_L) begin
      if (s == CH_1) leds[0] = 1'b1;
      if (s == CH_2) leds[1] = 1'b1;
      if (s == CH_0) leds = 2'b00;
      push_ok();
      return;
    end else begin
      push_result(1'b1, CH_QUERY, 1'b0);
      push_result(1'b1, CH_NL, 1'b1);
      return;
    end
    if (done) push_ok();
    else push_result(1'b0, 8'h00, 1'b1);
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [15:0] d);
    case (idx)
      CFG_SERVO_MIN_PULSE: reg_min_pulse = d;
      CFG_SERVO_SPAN:      reg_span = d;
      CFG_SERVO_FRAME:     reg_frame = d;
      CFG_SERVO_REPEATS:   reg_repeats = d[7:0];
      CFG_TONE_HALF:       reg_half = d;
      CFG_TONE_CYCLES:     reg_cycles = d;
      default: ;
    endcase
  endfunction

  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count < 100)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_item(op, b);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_item(OP_BYTE, txt[i]);
  endtask

  // tick until the running action ends, with stray bytes mixed in unless quiet
  task automatic finish_action();
    while (act_mode != MODE_IDLE) begin
      if (!quiet && $urandom_range(0, 9) == 0)
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      else
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_line(input string txt);
    send_text(txt);
    finish_action();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    apply_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_servo(input logic [15:0] mn, input logic [15:0] sp,
                           input logic [15:0] fr, input logic [15:0] rp);
    wait_idle();
    write_reg(CFG_SERVO_MIN_PULSE, mn);
    write_reg(CFG_SERVO_SPAN, sp);
    write_reg(CFG_SERVO_FRAME, fr);
    write_reg(CFG_SERVO_REPEATS, rp);
  endtask

  task automatic set_tone(input logic [15:0] hp, input logic [15:0] cy);
    wait_idle();
    write_reg(CFG_TONE_HALF, hp);
    write_reg(CFG_TONE_CYCLES, cy);
  endtask

  task automatic test_led_and_unknown();
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_text("L1\nL2\nL0\nL2\nL7\nL\n\nQ1\nl1\n");
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, CH_NL);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, CH_NL);
  endtask

  task automatic test_servo_angles();
    set_servo(16'd3, 16'd10, 16'd12, 16'd2);
    send_text("S90\n");
    // newline inside an action must not complete this line
    send_text("L1\n");
    finish_action();
    send_line("S -7\n");
    send_line("S+400\n");
    send_line("S180\n");
    send_item(OP_BYTE, CH_S);
    send_item(OP_BYTE, CH_TAB);
    send_item(OP_BYTE, CH_VT);
    send_item(OP_BYTE, CH_FF);
    send_item(OP_BYTE, CH_CR);
    send_line(" 45\n");
    send_line("S 12x9\n");
    send_line("S\n");
    send_line("S--5\n");
    send_line("S7abcdefghijklmnop\n");
  endtask

  task automatic test_tone();
    set_tone(16'd2, 16'd3);
    send_line("B\n");
    send_line("Bxyz\n");
  endtask

  task automatic test_zero_lengths();
    set_servo(16'd0, 16'd0, 16'd5, 16'd2);
    send_line("S100\n");
    set_servo(16'd4, 16'd0, 16'd0, 16'd3);
    send_line("S9\n");
    set_servo(16'd4, 16'd20, 16'd30, 16'd0);
    send_line("S60\n");
    set_tone(16'd0, 16'd3);
    send_line("B\n");
    set_tone(16'd0, 16'd65535);
    send_line("B\n");
    set_tone(16'd4, 16'd0);
    send_line("B\n");
  endtask

  task automatic test_register_extremes();
    quiet = 1'b1;
    set_servo(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    send_line("S180\n");
    set_servo(16'd0, 16'd0, 16'd1, 16'd255);
    send_line("S\n");
    set_tone(16'hFFFF, 16'd1);
    send_line("B\n");
    quiet = 1'b0;
  endtask

  task automatic send_random_line();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_item(OP_BYTE, CH_S);
      repeat ($urandom_range(0, 2)) send_item(OP_BYTE, pick_blank());
      case ($urandom_range(0, 9))
        0, 1: send_item(OP_BYTE, CH_MINUS);
        2, 3: send_item(OP_BYTE, CH_PLUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 4)) send_item(OP_BYTE, 8'(CH_0 + $urandom_range(0, 9)));
      if ($urandom_range(0, 4) == 0) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end else if (r < 60) begin
      send_item(OP_BYTE, CH_B);
      if ($urandom_range(0, 3) == 0) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end else if (r < 80) begin
      send_item(OP_BYTE, CH_L);
      case ($urandom_range(0, 3))
        0: send_item(OP_BYTE, CH_0);
        1: send_item(OP_BYTE, CH_1);
        2: send_item(OP_BYTE, CH_2);
        default: send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      endcase
    end else if (r < 90) begin
      repeat ($urandom_range(0, 4)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      // leave the line open so the noise leads the next one
      repeat ($urandom_range(1, 3)) send_item($urandom_range(0, 1), 8'($urandom_range(0, 255)));
      return;
    end
    send_item(OP_BYTE, CH_NL);
    finish_action();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      set_servo(16'($urandom_range(0, 20)), 16'($urandom_range(0, 60)),
                16'($urandom_range(0, 40)),
                {8'($urandom), 8'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4))});
      set_tone(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
      quiet = (ph == 2);
      repeat (12) send_random_line();
      finish_action();
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin : check_results
    pin_reply_t want;
    cycle_count++;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count < 100) $display("%0t: result with nothing expected", $time);
      end else begin
        want = expected_q.pop_front();
        cmp_field("servo_pin", want.servo, out_servo_pin);
        cmp_field("buzzer_pin", want.buzzer, out_buzzer_pin);
        cmp_field("led_zero", want.led0, out_led_zero);
        cmp_field("led_one", want.led1, out_led_one);
        cmp_field("reply_valid", want.reply_valid, out_reply_valid);
        cmp_field("reply_byte", want.reply_byte, out_reply_byte);
        cmp_field("last", want.last_item, out_last);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("tb_serial_line_servo_tone_led_controller_core: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_led_and_unknown();
    test_servo_angles();
    test_tone();
    test_zero_lengths();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_serial_line_servo_tone_led_controller_core: PASS");
    end else begin
      $display("tb_serial_line_servo_tone_led_controller_core: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
